/* rtl/elrs_pkg.sv */
`default_nettype none
package elrs_pkg;

	// one extent table entry
	typedef struct packed {
		logic [31:0] img_start;
		logic [31:0] img_end;
		logic [47:0] disk_start;
	} ext_t;

	// configuration register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_CHUNK_COUNT = 2'd0;
	localparam logic [1:0] REG_SECTOR_LOG2 = 2'd1;
	localparam logic [1:0] REG_HDD_MODE    = 2'd2;

	// input item kinds on s_tuser
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam int XFER_MAX    = 64;
	localparam int MAX_COUNT   = 32;
	localparam int IMG_SHIFT   = 11;   // 2048-byte image sector
	localparam int HDD_SHIFT   = 9;    // 512-byte image sector
	localparam int XFER_BYTES  = 32768;

	// m_tdata layout
	localparam int OUT_LBA_LO  = 0;
	localparam int OUT_CNT_LO  = 48;
	localparam int OUT_BUF_LO  = 55;
	localparam int OUT_W       = 72;

	// s_tdata layout
	localparam int IN_IDX_LO   = 0;
	localparam int IN_ISTR_LO  = 6;
	localparam int IN_IEND_LO  = 38;
	localparam int IN_DISK_LO  = 70;
	localparam int IN_LBA_LO   = 118;
	localparam int IN_CNT_LO   = 150;
	localparam int IN_W        = 160;

	function automatic logic holds(input ext_t e, input logic [32:0] lba);
		holds = (lba >= {1'b0, e.img_start}) && (lba <= {1'b0, e.img_end});
	endfunction

endpackage
`default_nettype wire

/* rtl/extent_lba_remap_splitter_top.sv */
`default_nettype none
// Extent remap splitter. A load transaction (s_tuser = 0) writes one extent into the
// table. A read transaction (s_tuser = 1) is cut into pieces, one per extent crossed;
// each piece goes through a cache read and check, then setup of piece length and disk
// LBA, then its transfers. A cache miss first scans the table entries, up to the lesser
// of chunk_count and MAX_EXTENTS, reading the extent memory one entry a cycle.
// s_tready is low from the accepted read until its last transfer is taken. A request
// of count zero gives no transfers. No table reset pass: entries read as garbage until
// loaded.
module extent_lba_remap_splitter_top #(
	parameter int MAX_EXTENTS = 64
) (
	input  wire                       clk,
	input  wire                       arst_n,
	// s_tdata: entry_index[5:0], entry_img_start[37:6], entry_img_end[69:38],
	//          entry_disk_start[117:70], request_lba[149:118], request_count[155:150]
	input  wire                       s_tvalid,
	output logic                      s_tready,
	input  wire [elrs_pkg::IN_W-1:0]  s_tdata,
	input  wire                       s_tuser,    // func
	// m_tdata: disk_lba[47:0], xfer_sectors[54:48], buffer_offset[71:55]
	output logic                      m_tvalid,
	input  wire                       m_tready,
	output logic [elrs_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tuser,    // mapped
	output logic                      m_tlast,
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire [3:0]                 paddr,
	input  wire [31:0]                pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import elrs_pkg::*;

	localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int LW = (CW > 7) ? CW : 7;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CREAD = 3'd1;
	localparam logic [2:0] S_CCHK  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_P1    = 3'd4;
	localparam logic [2:0] S_P2    = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]    state_q;
	logic [6:0]    chunk_q;
	logic [3:0]    log2_q;
	logic          hdd_q;

	ext_t          mem [MAX_EXTENTS];
	ext_t          rd_q;
	ext_t          ent_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] cache_q;
	logic          cache_valid_q;
	logic [LW-1:0] idx_q;
	logic [LW-1:0] idx_nx;
	logic [LW-1:0] lim;

	logic [32:0]   cur_q;
	logic [5:0]    left_q;
	logic [5:0]    piece_q;
	logic [31:0]   off_q;
	logic          hit_q;
	logic [47:0]   lba_q;
	logic [7:0]    tmp_q;
	logic [16:0]   buf_q;
	logic [16:0]   pbuf_q;

	logic [1:0]    shift;
	logic          cfg_wr;
	logic          s_acc;
	logic          m_acc;
	logic [LW-1:0] in_idx;
	logic [5:0]    in_cnt;
	logic [32:0]   room;
	logic [6:0]    xfer_c;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= '0;
			log2_q  <= 4'd9;
			hdd_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_CHUNK_COUNT: chunk_q <= pwdata[6:0];
				REG_SECTOR_LOG2: log2_q  <= pwdata[3:0];
				REG_HDD_MODE:    hdd_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_CHUNK_COUNT: prdata = {25'd0, chunk_q};
			REG_SECTOR_LOG2: prdata = {28'd0, log2_q};
			REG_HDD_MODE:    prdata = {31'd0, hdd_q};
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		if (hdd_q)              shift = 2'd0;
		else if (log2_q <= 4'd9) shift = 2'd2;
		else if (log2_q == 4'd10) shift = 2'd1;
		else                    shift = 2'd0;
	end

	assign lim    = (LW'(chunk_q) < LW'(MAX_EXTENTS)) ? LW'(chunk_q) : LW'(MAX_EXTENTS);
	assign idx_nx = idx_q + LW'(1);
	assign in_idx = LW'(s_tdata[IN_IDX_LO +: 6]);
	assign in_cnt = s_tdata[IN_CNT_LO +: 6];

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (state_q == S_OUT);
	assign m_acc    = m_tvalid && m_tready;

	// table write port
	always_ff @(posedge clk) begin
		if (s_acc && s_tuser == FUNC_LOAD && in_idx < LW'(MAX_EXTENTS)) begin
			mem[in_idx[AW-1:0]] <= ext_t'({s_tdata[IN_ISTR_LO +: 32],
				s_tdata[IN_IEND_LO +: 32], s_tdata[IN_DISK_LO +: 48]});
		end
	end

	// read address is chosen for the state that consumes the data next cycle
	always_comb begin
		unique case (state_q)
			S_CCHK:  rd_addr = '0;
			S_SCAN:  rd_addr = idx_nx[AW-1:0];
			default: rd_addr = cache_q;
		endcase
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign room   = {1'b0, ent_q.img_end} - cur_q + 33'd1;
	assign xfer_c = (tmp_q >= 8'(XFER_MAX)) ? 7'(XFER_MAX) : tmp_q[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cache_q       <= '0;
			cache_valid_q <= 1'b1;
			idx_q         <= '0;
			left_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_acc && s_tuser == FUNC_READ && in_cnt != 6'd0) begin
						left_q  <= (in_cnt > 6'(MAX_COUNT)) ? 6'(MAX_COUNT) : in_cnt;
						state_q <= S_CREAD;
					end
				end
				S_CREAD: state_q <= S_CCHK;
				S_CCHK: begin
					idx_q <= '0;
					if (cache_valid_q && holds(rd_q, cur_q)) begin
						state_q <= S_P1;
					end else begin
						cache_valid_q <= 1'b0;
						state_q       <= (lim == '0) ? S_P1 : S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_nx;
					if (holds(rd_q, cur_q)) begin
						cache_q       <= idx_q[AW-1:0];
						cache_valid_q <= 1'b1;
						state_q       <= S_P1;
					end else if (idx_nx == lim) begin
						state_q <= S_P1;
					end
				end
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_OUT;
				S_OUT: begin
					if (m_acc && tmp_q <= 8'(XFER_MAX)) begin
						left_q  <= left_q - piece_q;
						state_q <= (left_q == piece_q) ? S_IDLE : S_CREAD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cur_q <= {1'b0, s_tdata[IN_LBA_LO +: 32]};
				buf_q <= '0;
			end
			S_CCHK: begin
				ent_q <= rd_q;
				hit_q <= cache_valid_q && holds(rd_q, cur_q);
			end
			S_SCAN: begin
				ent_q <= rd_q;
				hit_q <= holds(rd_q, cur_q);
			end
			S_P1: begin
				piece_q <= (hit_q && {27'd0, left_q} > room) ? room[5:0] : left_q;
				off_q   <= cur_q[31:0] - ent_q.img_start;
			end
			S_P2: begin
				lba_q  <= hit_q ? ent_q.disk_start + {14'd0, {2'd0, off_q} << shift}
				                : {15'd0, cur_q};
				tmp_q  <= 8'(piece_q) << shift;
				pbuf_q <= buf_q;
			end
			S_OUT: begin
				if (m_acc) begin
					if (tmp_q > 8'(XFER_MAX)) begin
						tmp_q  <= tmp_q - 8'(XFER_MAX);
						lba_q  <= lba_q + 48'(XFER_MAX);
						pbuf_q <= pbuf_q + 17'(XFER_BYTES);
					end else begin
						cur_q <= cur_q + 33'(piece_q);
						buf_q <= buf_q + (17'(piece_q) << (hdd_q ? HDD_SHIFT : IMG_SHIFT));
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tdata = {pbuf_q, xfer_c, lba_q};
	assign m_tuser = hit_q;
	assign m_tlast = (tmp_q <= 8'(XFER_MAX)) && (left_q == piece_q);

endmodule
`default_nettype wire

/* rtl/elrs_checker.sv */
`default_nettype none
module elrs_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        s_tready,
	input wire                        m_tvalid,
	input wire                        m_tready,
	input wire [elrs_pkg::OUT_W-1:0]  m_tdata,
	input wire                        m_tuser,
	input wire                        m_tlast
);
	import elrs_pkg::*;

	// one request at a time: no new transaction taken while a transfer is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a transfer is pending");

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[OUT_CNT_LO +: 7] != 7'd0) &&
		             (m_tdata[OUT_CNT_LO +: 7] <= 7'(XFER_MAX)))
		else $error("transfer length out of range");

	// passthrough LBA is the image LBA, at most 33 bits
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[47:33] == 15'd0))
		else $error("passthrough LBA too wide");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("not ready after final transfer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled transfer changed");

endmodule

bind extent_lba_remap_splitter_top elrs_checker u_elrs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire

/* tb/sv/remap_checker.sv */
`timescale 1ns / 100ps
module remap_checker
	import elrs_pkg::*;
(
	input  wire                clk,
	input  wire                arst_n,
	input  wire                s_tvalid,
	input  wire                s_tready,
	input  wire [IN_W-1:0]     s_tdata,
	input  wire                s_tuser,
	input  wire                m_tvalid,
	input  wire                m_tready,
	input  wire [OUT_W-1:0]    m_tdata,
	input  wire                m_tuser,
	input  wire                m_tlast,
	input  wire                psel,
	input  wire                penable,
	input  wire                pwrite,
	input  wire [3:0]          paddr,
	input  wire [31:0]         pwdata,
	input  wire [31:0]         prdata,
	input  wire                pready,
	output int                 faults,
	output int                 xfers_due
);

	typedef struct packed {
		logic [47:0] lba;
		logic [6:0]  sectors;
		logic [16:0] boff;
		logic        mapped;
		logic        last;
	} xfer_t;

	logic [31:0] ext_start [0:63];
	logic [31:0] ext_end   [0:63];
	logic [47:0] ext_disk  [0:63];
	logic [5:0]  hot_idx;
	logic        hot_ok;
	logic [6:0]  cfg_chunks;
	logic [3:0]  cfg_log2;
	logic        cfg_hdd;

	xfer_t due_xfers[$];
	xfer_t got, want;
	logic [31:0] reg_val;

	function automatic logic covers(input int i, input logic [32:0] lba);
		return lba >= {1'b0, ext_start[i]} && lba <= {1'b0, ext_end[i]};
	endfunction

	task automatic flag(input string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endtask

	// walk the request piece by piece, each piece split into transfers of at most 64 sectors
	task automatic split_request(input logic [31:0] lba_in, input logic [5:0] cnt_in);
		logic [32:0] cur;
		logic [63:0] room;
		logic [63:0] delta;
		logic [47:0] dlba;
		logic        hit;
		int          left, piece, shift, lim, sect, c, i, lg, acc, poff;
		xfer_t       x;
		xfer_t       pend[$];

		if (cfg_hdd) begin
			shift = 0;
		end else begin
			lg = cfg_log2;
			if (lg < 9) lg = 9;
			if (lg > 11) lg = 11;
			shift = 11 - lg;
		end
		cur = {1'b0, lba_in};
		left = (cnt_in > 32) ? 32 : cnt_in;
		lim = (cfg_chunks < 64) ? cfg_chunks : 64;
		acc = 0;
		while (left > 0) begin
			piece = left;
			if (!(hot_ok && covers(hot_idx, cur))) begin
				hot_ok = 1'b0;
				for (i = 0; i < lim; i++) begin
					if (covers(i, cur)) begin
						hot_idx = 6'(i);
						hot_ok = 1'b1;
						break;
					end
				end
			end
			hit = hot_ok;
			if (hit) begin
				// extent end may be all ones: room is taken in 64 bits
				room = {32'b0, ext_end[hot_idx]} - {31'b0, cur} + 64'd1;
				if (piece > room) piece = int'(room);
				delta = {31'b0, cur} - {32'b0, ext_start[hot_idx]};
				delta = delta << shift;
				dlba = ext_disk[hot_idx] + delta[47:0];
			end else begin
				dlba = {15'b0, cur};
			end
			sect = piece << shift;
			poff = acc;
			while (sect > 0) begin
				c = (sect >= XFER_MAX) ? XFER_MAX : sect;
				sect -= c;
				x.lba = dlba;
				x.sectors = 7'(c);
				x.boff = 17'(poff);
				x.mapped = hit;
				x.last = 1'b0;
				pend.push_back(x);
				dlba = dlba + 48'(c);
				poff += XFER_BYTES;
			end
			cur = cur + 33'(piece);
			left -= piece;
			acc += piece * (cfg_hdd ? 512 : 2048);
		end
		if (pend.size() > 0)
			pend[pend.size() - 1].last = 1'b1;
		foreach (pend[k])
			due_xfers.push_back(pend[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) begin
				ext_start[i] = '0;
				ext_end[i] = '0;
				ext_disk[i] = '0;
			end
			hot_idx = '0;
			hot_ok = 1'b1;
			cfg_chunks = '0;
			cfg_log2 = 4'd9;
			cfg_hdd = 1'b0;
			due_xfers.delete();
			faults = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.lba = m_tdata[OUT_LBA_LO +: 48];
				got.sectors = m_tdata[OUT_CNT_LO +: 7];
				got.boff = m_tdata[OUT_BUF_LO +: 17];
				got.mapped = m_tuser;
				got.last = m_tlast;
				if (due_xfers.size() == 0) begin
					flag($sformatf("unexpected transfer: lba=%h sectors=%0d offset=%h mapped=%b last=%b",
						got.lba, got.sectors, got.boff, got.mapped, got.last));
				end else begin
					want = due_xfers.pop_front();
					if (got.lba !== want.lba || got.sectors !== want.sectors ||
							got.boff !== want.boff || got.mapped !== want.mapped ||
							got.last !== want.last)
						flag($sformatf({"transfer mismatch: expected lba=%h sectors=%0d offset=%h",
							" mapped=%b last=%b, got lba=%h sectors=%0d offset=%h mapped=%b last=%b"},
							want.lba, want.sectors, want.boff, want.mapped, want.last,
							got.lba, got.sectors, got.boff, got.mapped, got.last));
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == FUNC_LOAD) begin
					ext_start[s_tdata[IN_IDX_LO +: 6]] = s_tdata[IN_ISTR_LO +: 32];
					ext_end[s_tdata[IN_IDX_LO +: 6]] = s_tdata[IN_IEND_LO +: 32];
					ext_disk[s_tdata[IN_IDX_LO +: 6]] = s_tdata[IN_DISK_LO +: 48];
				end else begin
					split_request(s_tdata[IN_LBA_LO +: 32], s_tdata[IN_CNT_LO +: 6]);
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_CHUNK_COUNT: cfg_chunks = pwdata[6:0];
						REG_SECTOR_LOG2: cfg_log2 = pwdata[3:0];
						REG_HDD_MODE:    cfg_hdd = pwdata[0];
						default: ;
					endcase
				end else begin
					case (paddr[3:2])
						REG_CHUNK_COUNT: reg_val = {25'b0, cfg_chunks};
						REG_SECTOR_LOG2: reg_val = {28'b0, cfg_log2};
						REG_HDD_MODE:    reg_val = {31'b0, cfg_hdd};
						default:         reg_val = prdata;
					endcase
					if (prdata !== reg_val)
						flag($sformatf("register read mismatch at %h: expected %h, got %h",
							paddr, reg_val, prdata));
				end
			end
		end
		xfers_due = due_xfers.size();
	end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
module testbench;
	import elrs_pkg::*;

	localparam int RAND_ITEMS = 65;
	localparam int PHASES     = 5;
	localparam int QUIET      = 150;      // covers a full 64-entry scan after the last transfer
	localparam int LIMIT      = 4000000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             s_tuser = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             m_tuser;
	logic             m_tlast;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [3:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;

	int               faults;
	int               xfers_due;
	int               cycles = 0;
	int               send_calm = 0;
	int               take_calm = 0;

	// extents as loaded, used only to aim requests at them
	logic [31:0]      ext_lo [0:63];
	logic [31:0]      ext_hi [0:63];

	extent_lba_remap_splitter_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	remap_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.faults(faults), .xfers_due(xfers_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// wait before a transaction; now and then a stretch with no waits at all
	function automatic int pick_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(10, 30);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	initial begin : sink
		int n;
		forever begin
			n = pick_wait(take_calm);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			@(negedge clk);
		end
	end

	function automatic logic [IN_W-1:0] pack_item(input logic [5:0] idx, input logic [31:0] s,
			input logic [31:0] e, input logic [47:0] d, input logic [31:0] lba,
			input logic [5:0] cnt);
		logic [IN_W-1:0] v;
		v = '0;
		v[IN_IDX_LO +: 6] = idx;
		v[IN_ISTR_LO +: 32] = s;
		v[IN_IEND_LO +: 32] = e;
		v[IN_DISK_LO +: 48] = d;
		v[IN_LBA_LO +: 32] = lba;
		v[IN_CNT_LO +: 6] = cnt;
		return v;
	endfunction

	task automatic send(input logic func, input logic [IN_W-1:0] data);
		int n;
		n = pick_wait(send_calm);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= data;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
	endtask

	task automatic put_load(input logic [5:0] idx, input logic [31:0] s, input logic [31:0] e,
			input logic [47:0] d);
		ext_lo[idx] = s;
		ext_hi[idx] = e;
		send(FUNC_LOAD, pack_item(idx, s, e, d, $urandom, 6'($urandom)));
	endtask

	task automatic put_read(input logic [31:0] lba, input logic [5:0] cnt);
		send(FUNC_READ, pack_item(6'($urandom), $urandom, $urandom,
			48'({$urandom, $urandom}), lba, cnt));
	endtask

	task automatic put_random_extent(input logic [5:0] idx);
		logic [31:0] s, e;
		logic [47:0] d;
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			s = $urandom;
			e = $urandom;
		end else if (r == 1) begin
			s = 32'hFFFF_FF00 + 32'($urandom_range(0, 224));
			e = 32'hFFFF_FFFF;
		end else begin
			s = 32'($urandom_range(0, 2047));
			e = s + 32'((r == 2) ? $urandom_range(100, 5000) : $urandom_range(1, 24)) - 32'd1;
		end
		d = 48'({$urandom, $urandom});
		if ($urandom_range(0, 7) == 0)
			d = 48'hFFFF_FFFF_FF00 + 48'($urandom_range(0, 255));
		put_load(idx, s, e, d);
	endtask

	task automatic random_item();
		logic [31:0] lba;
		logic [5:0]  cnt;
		int k;
		if ($urandom_range(0, 5) == 0) begin
			put_random_extent(6'($urandom_range(0, 63)));
		end else begin
			k = $urandom_range(0, 63);
			case ($urandom_range(0, 7))
				0:       lba = $urandom;
				1:       lba = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
				2:       lba = ext_hi[k] - 32'($urandom_range(0, 5));
				3:       lba = 32'($urandom_range(0, 2100));
				default: lba = ext_lo[k] + 32'($urandom_range(0, 40)) - 32'd3;
			endcase
			if ($urandom_range(0, 9) == 0)
				cnt = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
			else
				cnt = 6'($urandom_range(1, 32));
			put_read(lba, cnt);
		end
	endtask

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	// write, then read back
	task automatic set_reg(input logic [1:0] idx, input logic [31:0] val);
		apb_access(1'b1, idx, val);
		apb_access(1'b0, idx, 32'd0);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_cfg(input int chunks, input int lg, input int hdd);
		set_reg(REG_CHUNK_COUNT, 32'(chunks));
		set_reg(REG_SECTOR_LOG2, 32'(lg));
		set_reg(REG_HDD_MODE, 32'(hdd));
	endtask

	// block idle: nothing due, and time for a zero-count request or a scan to finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (xfers_due != 0) @(negedge clk);
		repeat (QUIET) @(negedge clk);
	endtask

	initial begin : stim
		int p, i;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_cfg(8, 9, 0);
		put_load(6'd0, 32'd100, 32'd199, 48'd1000);
		put_load(6'd1, 32'd200, 32'd200, 48'hFFFF_FFFF_FFF0);
		put_load(6'd2, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 48'd5000);
		put_load(6'd3, 32'd0, 32'd0, 48'd0);
		put_load(6'd4, 32'd300, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
		put_load(6'd5, 32'd150, 32'd160, 48'd7);
		put_load(6'd6, 32'd1000, 32'd1009, 48'hFFFF_FFFF_FFFF);
		put_load(6'd7, 32'd400, 32'd399, 48'h8000_0000_0000);    // empty extent
		put_load(6'd63, 32'd50, 32'd60, 48'd1);
		put_read(32'd100, 6'd1);
		put_read(32'd190, 6'd32);          // crosses into a wrapping extent, then unmapped
		put_read(32'hFFFF_FFF8, 6'd32);    // runs past the top of the image space
		put_read(32'd0, 6'd0);
		put_read(32'd0, 6'd63);
		put_read(32'd1000, 6'd32);
		put_read(32'd155, 6'd5);
		settle();
		set_cfg(8, 9, 1);
		put_read(32'd1000, 6'd32);
		put_read(32'd190, 6'd32);
		settle();
		set_cfg(8, 10, 0);
		put_read(32'd1000, 6'd20);
		settle();
		set_cfg(0, 0, 0);                   // sector size below range, no search
		put_read(32'd250, 6'd3);
		put_read(32'd100, 6'd2);
		settle();
		set_cfg(8, 15, 0);                  // sector size above range
		put_read(32'hFFFF_FFFF, 6'd32);
		put_read(32'd0, 6'd1);

		settle();
		for (i = 0; i < 64; i++)
			put_random_extent(6'(i));
		for (p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: set_cfg(64, 9, 0);
				1: set_cfg(127, 11, 0);
				2: set_cfg(1, 10, 1);
				default: set_cfg($urandom_range(0, 127), $urandom_range(0, 15), $urandom_range(0, 1));
			endcase
			repeat (RAND_ITEMS / PHASES) random_item();
		end

		settle();
		if (faults == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* extent_lba_remap_splitter_top.f */
rtl/elrs_pkg.sv
rtl/extent_lba_remap_splitter_top.sv
rtl/elrs_checker.sv
tb/sv/remap_checker.sv
tb/sv/testbench.sv
